/* rtl/keyed_record_table_assert.svh */
// assertion macros shared by the record table rtl
// expects clk and rst_n in the including module, no other dependencies
`ifndef KEYED_RECORD_TABLE_ASSERT_SVH
`define KEYED_RECORD_TABLE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define KRT_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyed_record_table: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define KRT_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyed_record_table: next-cycle check failed");

`endif

/* rtl/krt_pkg.sv */
// types, codes and the name canonicalizing function of the record table
// no dependencies
`timescale 1ns / 1ps

package krt_pkg;

    localparam int KEY_W    = 72;
    localparam int AGE_W    = 8;
    localparam int HEIGHT_W = 10;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_LIST   = 2'd3
    } krt_cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_MISS  = 2'd3
    } krt_status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_WALK  = 2'd1,
        S_FLUSH = 2'd2,
        S_DONE  = 2'd3
    } krt_state_t;

    typedef struct packed {
        logic [63:0]         head;
        logic [7:0]          tail;
        logic [AGE_W-1:0]    age;
        logic [HEIGHT_W-1:0] height;
    } krt_rec_t;

    // clear every character after the first zero character
    function automatic logic [KEY_W-1:0] krt_canon(input logic [KEY_W-1:0] key);
        logic [KEY_W-1:0] res;
        logic             ended;
        res   = '0;
        ended = 1'b0;
        for (int b = 0; b < 9; b++)
        begin
            if (key[KEY_W-1-8*b -: 8] == 8'd0)
            begin
                ended = 1'b1;
            end
            if (!ended)
            begin
                res[KEY_W-1-8*b -: 8] = key[KEY_W-1-8*b -: 8];
            end
        end
        return res;
    endfunction

endpackage

/* rtl/keyed_record_table.sv */
// top level of the record table: command decode, slot walk and record memory
// depends on krt_pkg and keyed_record_table_assert.svh
`timescale 1ns / 1ps

// keyed record table: up to CAPACITY records (nine-character name, age, height)
// kept packed in slots 0 .. fill-1 of one synchronous memory. a command word
// is taken when start is high and busy is low. insert, and any command on an
// empty table, answers with a single result word in the cycle after it is
// taken and leaves busy low. remove, search and list walk the occupied slots
// through the memory read port, one slot per cycle, then pass a flush and a
// done state, busy high throughout; the final result is registered from done.
// remove shifts the later records down during the same walk, writing each
// slot back one below where it was read. result words are on the ports for
// exactly one cycle, marked by valid, and cannot be held off; last marks the
// final word of a command. search and list hold back each found record until
// the next one is found or the walk ends, so the final one can carry last.
// words without a record carry zero in hit and all record fields.

module keyed_record_table
    import krt_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [63:0] key_head,
    input  logic [7:0]  key_tail,
    input  logic [7:0]  age_in,
    input  logic [9:0]  height_in,
    output logic        valid,
    output logic [1:0]  status,
    output logic        hit,
    output logic [63:0] rec_head,
    output logic [7:0]  rec_tail,
    output logic [7:0]  rec_age,
    output logic [9:0]  rec_height,
    output logic        last
);

    // fill count holds 0 .. CAPACITY, slot index holds 0 .. CAPACITY-1
    localparam int FILL_W = $clog2(CAPACITY + 1);
    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [FILL_W-1:0] CAP_FILL = FILL_W'(CAPACITY);

    // record memory, one write and one registered read per cycle
    krt_rec_t slot_mem [CAPACITY];

    krt_state_t        state_reg, state_next;
    krt_cmd_t          cmd_reg, cmd_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic              pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]  pipe_idx_reg, pipe_idx_next;
    krt_rec_t          rd_data_reg;
    logic              found_reg, found_next;
    logic              pend_vld_reg, pend_vld_next;
    krt_rec_t          pend_reg, pend_next;

    logic              valid_reg, valid_next;
    krt_status_t       status_reg, status_next;
    logic              hit_reg, hit_next;
    krt_rec_t          rec_reg, rec_next;
    logic              last_reg, last_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    krt_rec_t          wr_data;

    logic              accept;
    krt_cmd_t          cmd_in;
    logic [KEY_W-1:0]  canon_key;
    logic [FILL_W-1:0] last_idx;
    logic              walk_end;
    logic              key_match;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cmd_in    = krt_cmd_t'(cmd);
    assign canon_key = krt_canon({key_head, key_tail});
    assign last_idx  = fill_reg - FILL_W'(1);
    assign walk_end  = (FILL_W'(rd_idx_reg) == last_idx);
    // stored names are already canonical
    assign key_match = ({rd_data_reg.head, rd_data_reg.tail} == key_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (cmd_in != CMD_INSERT) && (fill_reg != '0))
                begin
                    state_next = S_WALK;
                end
            end
            S_WALK:
            begin
                // last occupied slot read this cycle
                if (walk_end)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath, memory write port and result word
    always_comb
    begin
        cmd_next      = cmd_reg;
        key_next      = key_reg;
        fill_next     = fill_reg;
        rd_idx_next   = rd_idx_reg;
        pipe_vld_next = 1'b0;
        pipe_idx_next = rd_idx_reg;
        found_next    = found_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        wr_en         = 1'b0;
        wr_addr       = pipe_idx_reg;
        wr_data       = rd_data_reg;
        valid_next    = 1'b0;
        status_next   = STAT_OK;
        hit_next      = 1'b0;
        rec_next      = '0;
        last_next     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next      = cmd_in;
                    key_next      = canon_key;
                    rd_idx_next   = '0;
                    found_next    = 1'b0;
                    pend_vld_next = 1'b0;
                    if (cmd_in == CMD_INSERT)
                    begin
                        valid_next = 1'b1;
                        last_next  = 1'b1;
                        if (fill_reg == CAP_FILL)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            // append at the first free slot
                            wr_en     = 1'b1;
                            wr_addr   = IDX_W'(fill_reg);
                            wr_data   = '{head: canon_key[KEY_W-1:8],
                                          tail: canon_key[7:0],
                                          age: age_in, height: height_in};
                            fill_next = fill_reg + FILL_W'(1);
                        end
                    end
                    else if (fill_reg == '0)
                    begin
                        valid_next  = 1'b1;
                        last_next   = 1'b1;
                        status_next = STAT_EMPTY;
                    end
                end
            end
            S_WALK:
            begin
                // issue the read of the current slot
                pipe_vld_next = 1'b1;
                pipe_idx_next = rd_idx_reg;
                if (!walk_end)
                begin
                    rd_idx_next = rd_idx_reg + IDX_W'(1);
                end
            end
            S_FLUSH:
            begin
                // last read data is handled below
            end
            S_DONE:
            begin
                valid_next = 1'b1;
                last_next  = 1'b1;
                case (cmd_reg)
                    CMD_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            fill_next = fill_reg - FILL_W'(1);
                        end
                        else
                        begin
                            status_next = STAT_MISS;
                        end
                    end
                    CMD_SEARCH, CMD_LIST:
                    begin
                        if (pend_vld_reg)
                        begin
                            hit_next = 1'b1;
                            rec_next = pend_reg;
                        end
                        else
                        begin
                            status_next = STAT_MISS;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            default:
            begin
                valid_next = 1'b0;
            end
        endcase

        // slot data arriving from the memory in the cycle after its read
        if (pipe_vld_reg)
        begin
            if (cmd_reg == CMD_REMOVE)
            begin
                if (found_reg)
                begin
                    // close the gap: move this slot down by one
                    wr_en   = 1'b1;
                    wr_addr = pipe_idx_reg - IDX_W'(1);
                    wr_data = rd_data_reg;
                end
                else if (key_match)
                begin
                    found_next = 1'b1;
                end
            end
            else if ((cmd_reg == CMD_LIST) || key_match)
            begin
                // a newer record exists, so the held one is not the final word
                if (pend_vld_reg)
                begin
                    valid_next = 1'b1;
                    hit_next   = 1'b1;
                    rec_next   = pend_reg;
                end
                pend_next     = rd_data_reg;
                pend_vld_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            pipe_vld_reg <= 1'b0;
            found_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            pipe_vld_reg <= pipe_vld_next;
            found_reg    <= found_next;
            pend_vld_reg <= pend_vld_next;
            valid_reg    <= valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_reg      <= key_next;
        rd_idx_reg   <= rd_idx_next;
        pipe_idx_reg <= pipe_idx_next;
        pend_reg     <= pend_next;
        status_reg   <= status_next;
        hit_reg      <= hit_next;
        rec_reg      <= rec_next;
        last_reg     <= last_next;
    end

    // record memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= slot_mem[rd_idx_reg];
    end

    assign valid      = valid_reg;
    assign status     = status_reg;
    assign hit        = hit_reg;
    assign rec_head   = rec_reg.head;
    assign rec_tail   = rec_reg.tail;
    assign rec_age    = rec_reg.age;
    assign rec_height = rec_reg.height;
    assign last       = last_reg;

`include "keyed_record_table_assert.svh"

    `KRT_ASSERT_IMP(a_fill_bound, 1'b1, fill_reg <= CAP_FILL)
    `KRT_ASSERT_IMP(a_walk_in_range, state_reg == S_WALK, FILL_W'(rd_idx_reg) < fill_reg)
    `KRT_ASSERT_IMP(a_pipe_in_walk, pipe_vld_reg, state_reg == S_WALK || state_reg == S_FLUSH)
    `KRT_ASSERT_NXT(a_accept_answers, accept, valid_reg || busy)
    `KRT_ASSERT_NXT(a_done_final, state_reg == S_DONE, valid_reg && last_reg)
    `KRT_ASSERT_IMP(a_hit_is_ok, valid_reg && hit_reg, status_reg == STAT_OK)

endmodule

/* bench/tb_top.sv */
// self-checking bench for keyed_record_table: random and directed command words
// depends on krt_pkg (command and status codes, record type) and the rtl top level
`timescale 1ns / 1ps

module tb_top
    import krt_pkg::*;
();

    localparam int CAPACITY      = 16;
    localparam int NAME_POOL     = 5;
    localparam int TOTAL_WORDS   = 410;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_LIMIT  = 10;

    // one command word as it goes onto the input ports
    typedef struct packed {
        krt_cmd_t    op;
        logic [63:0] head;
        logic [7:0]  tail;
        logic [7:0]  age;
        logic [9:0]  height;
    } cmd_word_t;

    // one result word as it comes off the output ports
    typedef struct packed {
        krt_status_t status;
        logic        hit;
        krt_rec_t    rec;
        logic        last;
    } out_word_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [63:0] key_head;
    logic [7:0]  key_tail;
    logic [7:0]  age_in;
    logic [9:0]  height_in;
    logic        valid;
    logic [1:0]  status;
    logic        hit;
    logic [63:0] rec_head;
    logic [7:0]  rec_tail;
    logic [7:0]  rec_age;
    logic [9:0]  rec_height;
    logic        last;

    keyed_record_table #(.CAPACITY(CAPACITY)) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .key_head   (key_head),
        .key_tail   (key_tail),
        .age_in     (age_in),
        .height_in  (height_in),
        .valid      (valid),
        .status     (status),
        .hit        (hit),
        .rec_head   (rec_head),
        .rec_tail   (rec_tail),
        .rec_age    (rec_age),
        .rec_height (rec_height),
        .last       (last)
    );

    // pending command words, filled up front and drained by the driver
    cmd_word_t   cmd_queue[$];
    // result words still owed by the block, oldest first
    out_word_t   due_words[$];

    // mirror of the table contents, kept packed like the block keeps them
    krt_rec_t    shelf[CAPACITY];
    int          fill_level;

    // names that recur, so removes and searches actually find something
    logic [71:0] pool_key[NAME_POOL];
    int          pool_len[NAME_POOL];

    int          errors;
    int          sent;
    int          gap_pct;
    bit          took;
    cmd_word_t   nxt;
    cmd_word_t   seen;

    // 12 ns clock
    always #6 clk = ~clk;

    // ------------------------------------------------------------------
    // name handling
    // ------------------------------------------------------------------

    // a name stops at its first zero character, anything after is don't care
    function automatic logic [71:0] trim_key(input logic [71:0] raw);
        logic [71:0] cut;
        bit          stop;
        cut  = '0;
        stop = 1'b0;
        for (int c = 8; c >= 0; c--)
        begin
            if (raw[8*c +: 8] == 8'h00)
            begin
                stop = 1'b1;
            end
            if (!stop)
            begin
                cut[8*c +: 8] = raw[8*c +: 8];
            end
        end
        return cut;
    endfunction

    // pool name with fresh junk behind the terminator, same name once trimmed
    function automatic logic [71:0] dressed_name(input int idx);
        logic [71:0] raw;
        raw = pool_key[idx];
        for (int c = pool_len[idx] + 1; c < 9; c++)
        begin
            raw[71 - 8*c -: 8] = 8'($urandom_range(255));
        end
        return raw;
    endfunction

    // mostly recurring names, sometimes a fully random 72-bit key
    function automatic logic [71:0] pick_name();
        if ($urandom_range(99) < 82)
        begin
            return dressed_name($urandom_range(NAME_POOL - 1));
        end
        return {$urandom(), $urandom(), 8'($urandom_range(255))};
    endfunction

    // fill mode leans to insert, drain mode to remove, otherwise a mix
    function automatic krt_cmd_t pick_op(input int mode);
        int roll;
        int ins_w;
        int rem_w;
        int srch_w;
        roll = $urandom_range(99);
        case (mode)
            0:
            begin
                ins_w  = 65;
                rem_w  = 10;
                srch_w = 15;
            end
            1:
            begin
                ins_w  = 15;
                rem_w  = 60;
                srch_w = 15;
            end
            default:
            begin
                ins_w  = 35;
                rem_w  = 25;
                srch_w = 25;
            end
        endcase
        if (roll < ins_w)
        begin
            return CMD_INSERT;
        end
        if (roll < ins_w + rem_w)
        begin
            return CMD_REMOVE;
        end
        if (roll < ins_w + rem_w + srch_w)
        begin
            return CMD_SEARCH;
        end
        return CMD_LIST;
    endfunction

    task automatic queue_cmd(input krt_cmd_t op, input logic [71:0] key,
                             input logic [7:0] age, input logic [9:0] height);
        cmd_word_t w;
        w.op     = op;
        w.head   = key[71:8];
        w.tail   = key[7:0];
        w.age    = age;
        w.height = height;
        cmd_queue.push_back(w);
    endtask

    // ------------------------------------------------------------------
    // table predictor
    // ------------------------------------------------------------------

    task automatic owe_word(input krt_status_t st, input logic got_rec,
                            input krt_rec_t rec, input logic fin);
        out_word_t o;
        o.status = st;
        o.hit    = got_rec;
        o.rec    = got_rec ? rec : '0;
        o.last   = fin;
        due_words.push_back(o);
    endtask

    // apply one accepted command to the mirror and queue the words it owes
    task automatic predict_command(input cmd_word_t w);
        logic [71:0] key;
        int          n;
        int          pos;
        int          found[$];
        key = trim_key({w.head, w.tail});
        n   = fill_level;
        pos = -1;
        for (int i = 0; i < n; i++)
        begin
            if ({shelf[i].head, shelf[i].tail} == key)
            begin
                found.push_back(i);
            end
        end
        if (w.op == CMD_INSERT)
        begin
            if (n >= CAPACITY)
            begin
                owe_word(STAT_FULL, 1'b0, '0, 1'b1);
            end
            else
            begin
                shelf[n]   = {key, w.age, w.height};
                fill_level = n + 1;
                owe_word(STAT_OK, 1'b0, '0, 1'b1);
            end
        end
        else if (n == 0)
        begin
            owe_word(STAT_EMPTY, 1'b0, '0, 1'b1);
        end
        else if (w.op == CMD_LIST)
        begin
            for (int i = 0; i < n; i++)
            begin
                owe_word(STAT_OK, 1'b1, shelf[i], i == n - 1);
            end
        end
        else if (found.size() == 0)
        begin
            owe_word(STAT_MISS, 1'b0, '0, 1'b1);
        end
        else if (w.op == CMD_SEARCH)
        begin
            foreach (found[k])
            begin
                owe_word(STAT_OK, 1'b1, shelf[found[k]], k == found.size() - 1);
            end
        end
        else
        begin
            // remove: only the first match goes, the rest slide down one slot
            pos = found[0];
            for (int i = pos; i < n - 1; i++)
            begin
                shelf[i] = shelf[i + 1];
            end
            fill_level = n - 1;
            owe_word(STAT_OK, 1'b0, '0, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    task automatic report_fault(input string why, input out_word_t want,
                                input out_word_t got);
        errors++;
        if (errors <= REPORT_LIMIT)
        begin
            $display("%0t %s", $realtime, why);
            $display("  expected st=%0d hit=%0d name=%h_%h age=%0d ht=%0d last=%0d",
                     want.status, want.hit, want.rec.head, want.rec.tail,
                     want.rec.age, want.rec.height, want.last);
            $display("  actual   st=%0d hit=%0d name=%h_%h age=%0d ht=%0d last=%0d",
                     got.status, got.hit, got.rec.head, got.rec.tail,
                     got.rec.age, got.rec.height, got.last);
        end
    endtask

    task automatic check_word();
        out_word_t got;
        out_word_t want;
        got = {status, hit, rec_head, rec_tail, rec_age, rec_height, last};
        if (due_words.size() == 0)
        begin
            report_fault("result word with nothing outstanding", '0, got);
        end
        else
        begin
            want = due_words.pop_front();
            if (got.status !== want.status || got.hit !== want.hit
                || got.rec.head !== want.rec.head || got.rec.tail !== want.rec.tail
                || got.rec.age !== want.rec.age || got.rec.height !== want.rec.height
                || got.last !== want.last)
            begin
                report_fault("result word mismatch", want, got);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // monitor: samples both sides at the rising edge
    // ------------------------------------------------------------------

    // took tells the driver that the word on the ports was taken at this edge
    always @(posedge clk)
    begin
        took = 1'b0;
        if (rst_n)
        begin
            if (valid)
            begin
                check_word();
            end
            if (start && !busy)
            begin
                took = 1'b1;
                seen = {cmd, key_head, key_tail, age_in, height_in};
                predict_command(seen);
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: changes inputs at the falling edge
    // ------------------------------------------------------------------

    // idle rate per third of the run: light gaps, heavy gaps, back to back
    always @(negedge clk)
    begin
        if (sent < TOTAL_WORDS / 3)
        begin
            gap_pct = 10;
        end
        else if (sent < 2 * TOTAL_WORDS / 3)
        begin
            gap_pct = 67;
        end
        else
        begin
            gap_pct = 0;
        end
        // a word held under busy stays put until it is taken
        if (rst_n && (!start || took))
        begin
            if (cmd_queue.size() > 0 && $urandom_range(99) >= gap_pct)
            begin
                nxt = cmd_queue.pop_front();
                sent++;
                cmd       <= nxt.op;
                key_head  <= nxt.head;
                key_tail  <= nxt.tail;
                age_in    <= nxt.age;
                height_in <= nxt.height;
                start     <= 1'b1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus, reset and end of run
    // ------------------------------------------------------------------

    initial
    begin
        int mode;
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = CMD_INSERT;
        key_head   = '0;
        key_tail   = '0;
        age_in     = '0;
        height_in  = '0;
        errors     = 0;
        sent       = 0;
        took       = 1'b0;
        fill_level = 0;

        // recurring names, lengths from empty to the full nine characters
        for (int p = 0; p < NAME_POOL; p++)
        begin
            pool_len[p] = (p == 0) ? 9 : $urandom_range(9);
            pool_key[p] = '0;
            for (int c = 0; c < pool_len[p]; c++)
            begin
                pool_key[p][71 - 8*c -: 8] = 8'($urandom_range(1, 255));
            end
        end

        // directed: search, list and remove on an empty table
        queue_cmd(CMD_SEARCH, dressed_name(0), 8'd0, 10'd0);
        queue_cmd(CMD_LIST, pick_name(), 8'd0, 10'd0);
        queue_cmd(CMD_REMOVE, dressed_name(1), 8'd0, 10'd0);
        // all-ones name with top age and height, then the empty name with zeros
        queue_cmd(CMD_INSERT, {72{1'b1}}, 8'hff, 10'h3ff);
        queue_cmd(CMD_INSERT, 72'h0, 8'h00, 10'h000);
        // name ending early, junk behind the terminator must be dropped
        queue_cmd(CMD_INSERT, 72'h4142_005a_5a5a_5a5a_77, 8'h55, 10'h2aa);
        queue_cmd(CMD_SEARCH, 72'h4142_00a5_a5a5_a5a5_11, 8'h00, 10'h000);
        queue_cmd(CMD_SEARCH, 72'h00ff_ffff_ffff_ffff_ff, 8'h00, 10'h000);
        queue_cmd(CMD_SEARCH, 72'h4143_0000_0000_0000_00, 8'h00, 10'h000);
        queue_cmd(CMD_REMOVE, 72'h5a00_1234_5678_9abc_de, 8'h00, 10'h000);
        // fill to capacity with repeated names, then overflow
        for (int i = 0; i < CAPACITY - 3; i++)
        begin
            queue_cmd(CMD_INSERT, dressed_name(i % 3), 8'($urandom_range(255)),
                      10'($urandom_range(1023)));
        end
        queue_cmd(CMD_INSERT, dressed_name(3), 8'h12, 10'h034);
        // several hits for one name, drop the first of them, walk the whole table
        queue_cmd(CMD_SEARCH, dressed_name(0), 8'h00, 10'h000);
        queue_cmd(CMD_REMOVE, dressed_name(0), 8'h00, 10'h000);
        queue_cmd(CMD_LIST, 72'h0, 8'h00, 10'h000);

        // random: runs of sixteen words, each run biased to fill, drain or mix
        while (cmd_queue.size() < TOTAL_WORDS)
        begin
            mode = $urandom_range(2);
            for (int i = 0; i < 16 && cmd_queue.size() < TOTAL_WORDS; i++)
            begin
                queue_cmd(pick_op(mode), pick_name(), 8'($urandom_range(255)),
                          10'($urandom_range(1023)));
            end
        end

        // hold reset, then release it away from the sampling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // everything handed over, then every owed word seen, then a quiet tail
        while (sent < TOTAL_WORDS || start)
        begin
            @(posedge clk);
        end
        while (due_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
